[rtl/dtbp_pkg.sv]
// Shared types and constants for the devicetree blob token parser.
`timescale 1ns / 1ps
`default_nettype none

package dtbp_pkg;

    localparam logic [31:0] DT_MAGIC       = 32'hd00d_feed;
    localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOK_END_NODE   = 32'd2;
    localparam logic [31:0] TOK_PROP       = 32'd3;
    localparam logic [31:0] TOK_END        = 32'd9;
    localparam logic [31:0] ROOT_NAME      = 32'h2f00_0000;  // "/"

    typedef enum logic [2:0] {
        EV_MAGIC_ERR  = 3'd0,
        EV_NAME       = 3'd1,
        EV_PROP       = 3'd2,
        EV_NODE_END   = 3'd3,
        EV_STRUCT_END = 3'd4
    } event_t;

    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_SEEK   = 8'b0000_0010,
        PH_TOKEN  = 8'b0000_0100,
        PH_NAME   = 8'b0000_1000,
        PH_PLEN   = 8'b0001_0000,
        PH_POFF   = 8'b0010_0000,
        PH_PSKIP  = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [31:0] word;
        logic        first;
    } item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [31:0] name_chars;
        logic [2:0]  name_count;
        logic        name_last;
        logic [31:0] prop_length;
        logic [31:0] prop_name_addr;
        logic [31:0] data_addr;
    } result_t;

endpackage

`default_nettype wire

[rtl/dtbp_parser.sv]
// Token decoder: parse state registers and per-word next-state/result logic.
`timescale 1ns / 1ps
`default_nettype none

module dtbp_parser
    import dtbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire item_t       beat,
    input  wire logic [31:0] blob_base,
    output logic             res_valid,
    output result_t          res
);

    phase_t      phase_reg, phase_next;
    logic [29:0] word_index_reg, word_index_next;
    logic [31:0] struct_offset_reg, struct_offset_next;
    logic [31:0] strings_offset_reg, strings_offset_next;
    logic [31:0] pending_length_reg, pending_length_next;
    logic [29:0] skip_remaining_reg, skip_remaining_next;
    logic        name_first_word_reg, name_first_word_next;

    // state as seen by this beat (first restarts the blob)
    phase_t      ph;
    logic [29:0] idx;
    logic [31:0] soff, stroff, plen;
    logic [29:0] skip;
    logic        nfirst;
    logic [31:0] w;
    logic [31:0] next_addr;
    logic [2:0]  name_len;
    logic [31:0] name_mask;
    logic [31:0] plen_m1;

    always_comb
    begin
        w       = beat.word;
        ph      = beat.first ? PH_HEADER : phase_reg;
        idx     = beat.first ? 30'd0 : word_index_reg;
        soff    = beat.first ? 32'd0 : struct_offset_reg;
        stroff  = beat.first ? 32'd0 : strings_offset_reg;
        plen    = beat.first ? 32'd0 : pending_length_reg;
        skip    = beat.first ? 30'd0 : skip_remaining_reg;
        nfirst  = beat.first ? 1'b0 : name_first_word_reg;
        next_addr = blob_base + {idx + 30'd1, 2'b00};
        plen_m1   = plen - 32'd1;

        priority if (w[31:24] == 8'd0) name_len = 3'd0;
        else if (w[23:16] == 8'd0)     name_len = 3'd1;
        else if (w[15:8] == 8'd0)      name_len = 3'd2;
        else if (w[7:0] == 8'd0)       name_len = 3'd3;
        else                           name_len = 3'd4;

        unique case (name_len)
            3'd0:    name_mask = 32'h0000_0000;
            3'd1:    name_mask = 32'hff00_0000;
            3'd2:    name_mask = 32'hffff_0000;
            3'd3:    name_mask = 32'hffff_ff00;
            default: name_mask = 32'hffff_ffff;
        endcase

        phase_next           = ph;
        word_index_next      = idx + 30'd1;
        struct_offset_next   = soff;
        strings_offset_next  = stroff;
        pending_length_next  = plen;
        skip_remaining_next  = skip;
        name_first_word_next = nfirst;
        res_valid            = 1'b0;
        res                  = '0;

        unique case (ph)
            PH_HEADER:
            begin
                if (idx == 30'd0)
                begin
                    if (w != DT_MAGIC)
                    begin
                        phase_next    = PH_DONE;
                        res_valid     = 1'b1;
                        res.event_res = EV_MAGIC_ERR;
                    end
                end
                else if (idx == 30'd2)
                begin
                    struct_offset_next = w;
                end
                else if (idx == 30'd3)
                begin
                    strings_offset_next = w;
                    phase_next          = PH_SEEK;
                end
            end
            PH_SEEK, PH_TOKEN:
            begin
                // seek falls into token decode on the structure's first word
                if (ph == PH_TOKEN || idx >= soff[31:2])
                begin
                    phase_next = PH_TOKEN;
                    priority case (w)
                        TOK_BEGIN_NODE:
                        begin
                            phase_next           = PH_NAME;
                            name_first_word_next = 1'b1;
                        end
                        TOK_END_NODE:
                        begin
                            res_valid     = 1'b1;
                            res.event_res = EV_NODE_END;
                        end
                        TOK_PROP:
                        begin
                            phase_next = PH_PLEN;
                        end
                        TOK_END:
                        begin
                            phase_next    = PH_DONE;
                            res_valid     = 1'b1;
                            res.event_res = EV_STRUCT_END;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            PH_NAME:
            begin
                res_valid            = 1'b1;
                res.event_res        = EV_NAME;
                name_first_word_next = 1'b0;
                if (nfirst && name_len == 3'd0)
                begin
                    // empty root name
                    res.name_chars = ROOT_NAME;
                    res.name_count = 3'd1;
                    res.name_last  = 1'b1;
                    res.data_addr  = next_addr;
                    phase_next     = PH_TOKEN;
                end
                else if (name_len == 3'd4)
                begin
                    res.name_chars = w;
                    res.name_count = 3'd4;
                end
                else
                begin
                    res.name_chars = w & name_mask;
                    res.name_count = name_len;
                    res.name_last  = 1'b1;
                    res.data_addr  = next_addr;
                    phase_next     = PH_TOKEN;
                end
            end
            PH_PLEN:
            begin
                pending_length_next = w;
                phase_next          = PH_POFF;
            end
            PH_POFF:
            begin
                res_valid          = 1'b1;
                res.event_res      = EV_PROP;
                res.prop_length    = plen;
                res.prop_name_addr = blob_base + stroff + w;
                res.data_addr      = next_addr;
                if (plen == 32'd0)
                begin
                    phase_next = PH_TOKEN;
                end
                else
                begin
                    // padded words left after this one: ceil(len/4) - 1
                    skip_remaining_next = plen_m1[31:2];
                    phase_next          = PH_PSKIP;
                end
            end
            PH_PSKIP:
            begin
                if (skip == 30'd0)
                    phase_next = PH_TOKEN;
                else
                    skip_remaining_next = skip - 30'd1;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HEADER;
            word_index_reg      <= '0;
            struct_offset_reg   <= '0;
            strings_offset_reg  <= '0;
            pending_length_reg  <= '0;
            skip_remaining_reg  <= '0;
            name_first_word_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            word_index_reg      <= word_index_next;
            struct_offset_reg   <= struct_offset_next;
            strings_offset_reg  <= strings_offset_next;
            pending_length_reg  <= pending_length_next;
            skip_remaining_reg  <= skip_remaining_next;
            name_first_word_reg <= name_first_word_next;
        end
    end

endmodule

`default_nettype wire

[rtl/devicetree_blob_token_parser_top.sv]
// Top level of the devicetree blob token parser: handshake, input and result registers.
`timescale 1ns / 1ps
`default_nettype none
//
// Streams a flattened devicetree blob, one 32-bit big-endian word per beat on
// the item channel (item_valid / item_stall / item). item.first marks byte 0
// of a blob and restarts parsing. Each word yields zero or one result beat on
// the result channel (result_valid / result_stall / result): node name
// chunks, properties, node ends, structure end or a magic error.
// cfg_valid / cfg_ready / cfg_data writes blob_base, the address added to all
// reported addresses; cfg_ready is always high, write only while idle.
// Path: an accepted word loads the input register, and its decode lands in
// the result register; a held result register can delay that step.
// Throughput: one word per cycle while no result is held; the decoder is a
// single pass of phase logic, a 30-bit counter compare and 32-bit adds.
// Stall: a held result register stalls decode of the word in the input
// register, and that in turn raises item_stall; no beat is dropped.
// Reset: asynchronous, clears both valid flags, blob_base and parse state;
// the parser then expects a blob header.
//
module devicetree_blob_token_parser_top
    import dtbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    logic        s1_valid_reg;
    item_t       s1_item_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg;
    logic [31:0] blob_base_reg;

    logic        out_free;
    logic        s1_fire;
    logic        item_fire;
    logic        dec_valid;
    result_t     dec_res;

    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_fire    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign item_fire  = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    dtbp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_fire),
        .beat      (s1_item_reg),
        .blob_base (blob_base_reg),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    always_comb
    begin
        if (out_free)
            out_valid_next = s1_fire && dec_valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            blob_base_reg <= '0;
        end
        else
        begin
            if (item_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                blob_base_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
            s1_item_reg <= item;
        if (s1_fire && dec_valid)
            out_data_reg <= dec_res;
    end

    // input side only stalls behind a word that cannot drain
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && out_valid_reg)
        else $error("item_stall without a blocked word");

    // a blocked result with a waiting word must back-pressure the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall && s1_valid_reg |=> s1_valid_reg)
        else $error("waiting word lost while result blocked");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.event_res <= EV_STRUCT_END)
        else $error("result event code out of range");

    // a short name chunk always ends the name
    a_name_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_res == EV_NAME
            |-> result.name_count <= 3'd4
                && (result.name_count == 3'd4 || result.name_last))
        else $error("malformed name chunk");

    a_non_name_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_res != EV_NAME
            |-> result.name_chars == 32'd0 && result.name_count == 3'd0
                && !result.name_last)
        else $error("name fields set on a non-name event");

endmodule

`default_nettype wire

[verif/devicetree_blob_token_parser_top_tb.sv]
// Self-checking testbench for the devicetree blob token parser top level.
`timescale 1ns / 1ps

module devicetree_blob_token_parser_top_tb;
    import dtbp_pkg::*;

    // NOP has no constant in the package; the parser simply ignores it.
    localparam logic [31:0] TOK_NOP     = 32'd4;
    localparam int          CYCLE_LIMIT = 400_000;
    // Covers the input register and the result register, padded for slack.
    localparam int          SETTLE      = 8;
    localparam int          PHASE_WORDS = 70;
    localparam int          HOLD_CYCLES = 300;

    // One queued input beat. Rows from the directed table may carry a
    // typed-in result; everything else is checked against the predictor.
    typedef struct packed {
        item_t   it;
        logic    typed;
        logic    typed_has;
        result_t typed_res;
    } beat_rec_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    item_t       item         = '0;
    logic        result_stall = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [31:0] cfg_data     = '0;
    logic        item_stall;
    logic        result_valid;
    result_t     result;
    logic        cfg_ready;

    devicetree_blob_token_parser_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser model: own copy of the parse state and of blob_base.
    // ------------------------------------------------------------------
    phase_t      ph          = PH_HEADER;
    logic [29:0] widx        = '0;
    logic [31:0] st_off      = '0;
    logic [31:0] str_off     = '0;
    logic [31:0] plen        = '0;
    logic [29:0] skip_left   = '0;
    logic        name_head   = 1'b0;
    logic [31:0] base_addr   = '0;

    beat_rec_t   blob_words[$];      // beats waiting to be offered
    result_t     pending_events[$];  // events the block still owes us
    int          err_cnt     = 0;
    int          words_taken = 0;
    int          words_made  = 0;
    int          cut_left    = -1;   // >= 0 truncates the blob being built

    function automatic void clear_parse();
        ph        = PH_HEADER;
        widx      = '0;
        st_off    = '0;
        str_off   = '0;
        plen      = '0;
        skip_left = '0;
        name_head = 1'b0;
    endfunction

    function automatic bit decode_token(input logic [31:0] w, output result_t r);
        r = '0;
        case (w)
            TOK_BEGIN_NODE:
            begin
                ph        = PH_NAME;
                name_head = 1'b1;
            end
            TOK_END_NODE:
            begin
                r.event_res = EV_NODE_END;
                return 1'b1;
            end
            TOK_PROP:
            begin
                ph = PH_PLEN;
            end
            TOK_END:
            begin
                ph          = PH_DONE;
                r.event_res = EV_STRUCT_END;
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    // Advances the model by one blob word; returns 1 when an event is due.
    function automatic bit parse_word(input item_t it, output result_t r);
        logic [29:0] idx;
        logic [31:0] next_addr;
        logic [31:0] w;
        logic [31:0] mask;
        logic [31:0] nwords;
        int          k;
        bit          hit;
        hit = 1'b0;
        r   = '0;
        w   = it.word;
        if (it.first)
            clear_parse();
        idx       = widx;
        next_addr = base_addr + {idx + 30'd1, 2'b00};
        case (ph)
            PH_HEADER:
            begin
                if (idx == 30'd0) begin
                    if (w != DT_MAGIC) begin
                        ph          = PH_DONE;
                        r.event_res = EV_MAGIC_ERR;
                        hit         = 1'b1;
                    end
                end else if (idx == 30'd2) begin
                    st_off = w;
                end else if (idx == 30'd3) begin
                    str_off = w;
                    ph      = PH_SEEK;
                end
            end
            PH_SEEK:
            begin
                // structure begins at word 4 at the earliest, offset rounded down
                if ({2'b00, idx} >= (st_off >> 2)) begin
                    ph  = PH_TOKEN;
                    hit = decode_token(w, r);
                end
            end
            PH_TOKEN:
            begin
                hit = decode_token(w, r);
            end
            PH_NAME:
            begin
                k = 0;
                while (k < 4 && ((w >> (24 - 8 * k)) & 32'hFF) != 32'h0)
                    k++;
                r.event_res = EV_NAME;
                if (name_head && k == 0) begin
                    // empty root name is reported as "/"
                    r.name_chars = ROOT_NAME;
                    r.name_count = 3'd1;
                    r.name_last  = 1'b1;
                    r.data_addr  = next_addr;
                    ph           = PH_TOKEN;
                end else if (k == 4) begin
                    r.name_chars = w;
                    r.name_count = 3'd4;
                end else begin
                    // bytes after the terminator are masked off
                    mask         = (k == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> (8 * k));
                    r.name_chars = w & mask;
                    r.name_count = 3'(k);
                    r.name_last  = 1'b1;
                    r.data_addr  = next_addr;
                    ph           = PH_TOKEN;
                end
                name_head = 1'b0;
                hit       = 1'b1;
            end
            PH_PLEN:
            begin
                plen = w;
                ph   = PH_POFF;
            end
            PH_POFF:
            begin
                nwords = (plen >> 2) + ((plen[1:0] != 2'b00) ? 32'd1 : 32'd0);
                r.event_res      = EV_PROP;
                r.prop_length    = plen;
                r.prop_name_addr = base_addr + str_off + w;
                r.data_addr      = next_addr;
                hit              = 1'b1;
                if (nwords == 32'd0) begin
                    ph = PH_TOKEN;
                end else begin
                    skip_left = 30'(nwords - 32'd1);
                    ph        = PH_PSKIP;
                end
            end
            PH_PSKIP:
            begin
                if (skip_left == 30'd0)
                    ph = PH_TOKEN;
                else
                    skip_left = skip_left - 30'd1;
            end
            default:
            begin
            end
        endcase
        widx = idx + 30'd1;
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Table row helpers
    // ------------------------------------------------------------------
    function automatic result_t ev_only(input event_t e);
        result_t r;
        r           = '0;
        r.event_res = e;
        return r;
    endfunction

    function automatic result_t name_res(input logic [31:0] chars, input logic [2:0] cnt,
                                         input logic last, input logic [31:0] addr);
        result_t r;
        r            = '0;
        r.event_res  = EV_NAME;
        r.name_chars = chars;
        r.name_count = cnt;
        r.name_last  = last;
        r.data_addr  = addr;
        return r;
    endfunction

    // row checked against the model
    function automatic beat_rec_t pred(input logic first, input logic [31:0] word);
        beat_rec_t b;
        b          = '0;
        b.it.word  = word;
        b.it.first = first;
        return b;
    endfunction

    // row with its result typed in (has = 0: no result at all)
    function automatic beat_rec_t lit(input logic first, input logic [31:0] word,
                                      input logic has, input result_t res);
        beat_rec_t b;
        b           = pred(first, word);
        b.typed     = 1'b1;
        b.typed_has = has;
        b.typed_res = res;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Random blob builder
    // ------------------------------------------------------------------
    task automatic push_word(input logic first, input logic [31:0] w);
        if (cut_left == 0)
            return;
        if (cut_left > 0)
            cut_left--;
        blob_words.push_back(pred(first, w));
        words_made++;
    endtask

    function automatic logic [31:0] junk_token();
        logic [31:0] w;
        do begin
            w = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
        end while (w == TOK_BEGIN_NODE || w == TOK_END_NODE || w == TOK_PROP ||
                   w == TOK_END);
        return w;
    endfunction

    task automatic gen_name(input bit root);
        logic [31:0] w;
        int          len;
        bit          garbage;
        if (root && $urandom_range(0, 2) != 0) begin
            // empty root name, sometimes with junk after the terminator
            w = ($urandom_range(0, 1) == 0) ? 32'h0 : {8'h00, 24'($urandom)};
            push_word(1'b0, w);
            return;
        end
        len     = $urandom_range(1, 14);
        garbage = ($urandom_range(0, 3) == 0);
        for (int wi = 0; wi <= len / 4; wi++) begin
            w = '0;
            for (int b = 0; b < 4; b++) begin
                if (4 * wi + b < len)
                    w[31 - 8 * b -: 8] = 8'($urandom_range(1, 255));
                else if (4 * wi + b > len && garbage)
                    w[31 - 8 * b -: 8] = 8'($urandom);
            end
            push_word(1'b0, w);
        end
    endtask

    task automatic gen_prop();
        int len;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, 12);
            default:             len = $urandom_range(13, 48);
        endcase
        push_word(1'b0, TOK_PROP);
        push_word(1'b0, 32'(len));
        push_word(1'b0, $urandom);
        // value words may look like tokens; they must be skipped
        for (int i = 0; i < (len + 3) / 4; i++)
            push_word(1'b0, ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 9)) : $urandom);
    endtask

    task automatic gen_node(input int depth, input bit root);
        int nprops;
        int nkids;
        push_word(1'b0, TOK_BEGIN_NODE);
        gen_name(root);
        nprops = $urandom_range(0, 3);
        for (int i = 0; i < nprops; i++) begin
            if ($urandom_range(0, 5) == 0)
                push_word(1'b0, TOK_NOP);
            gen_prop();
        end
        nkids = (depth == 0) ? $urandom_range(0, 3) : (depth == 1) ? $urandom_range(0, 2) : 0;
        for (int i = 0; i < nkids; i++)
            gen_node(depth + 1, 1'b0);
        if ($urandom_range(0, 7) == 0)
            push_word(1'b0, junk_token());
        push_word(1'b0, TOK_END_NODE);
    endtask

    task automatic gen_blob();
        logic [31:0] soff;
        case ($urandom_range(0, 3))
            0:       soff = 32'($urandom_range(0, 15));       // inside the header
            1:       soff = 32'(16 + $urandom_range(0, 3));   // right after, maybe unaligned
            default: soff = 32'($urandom_range(16, 48));
        endcase
        push_word(1'b1, DT_MAGIC);
        push_word(1'b0, $urandom);
        push_word(1'b0, soff);
        push_word(1'b0, $urandom);
        for (int i = 4; i < int'(soff >> 2); i++)
            push_word(1'b0, $urandom);
        if ($urandom_range(0, 3) == 0)
            push_word(1'b0, TOK_NOP);
        gen_node(0, 1'b1);
        push_word(1'b0, TOK_END);
        repeat ($urandom_range(0, 2))
            push_word(1'b0, $urandom);
    endtask

    // Broken and random sequences.
    task automatic gen_noise();
        logic [31:0] w;
        case ($urandom_range(0, 4))
            0:
            begin
                do w = $urandom; while (w == DT_MAGIC);
                push_word(1'b1, w);
                repeat ($urandom_range(0, 5))
                    push_word(1'b0, $urandom);
            end
            1:
            begin
                repeat ($urandom_range(3, 20))
                    push_word(($urandom_range(0, 15) == 0), $urandom);
            end
            2:
            begin
                // huge structure offset: stays in the seek phase
                push_word(1'b1, DT_MAGIC);
                repeat (3)
                    push_word(1'b0, $urandom);
                repeat ($urandom_range(0, 6))
                    push_word(1'b0, $urandom);
            end
            3:
            begin
                cut_left = $urandom_range(3, 30);
                gen_blob();
                cut_left = -1;
            end
            default:
            begin
                // property with a random length, usually far too long
                push_word(1'b1, DT_MAGIC);
                push_word(1'b0, $urandom);
                push_word(1'b0, 32'd16);
                push_word(1'b0, $urandom);
                push_word(1'b0, TOK_BEGIN_NODE);
                push_word(1'b0, 32'h6100_0000);
                push_word(1'b0, TOK_PROP);
                push_word(1'b0, $urandom);
                push_word(1'b0, $urandom);
                repeat ($urandom_range(0, 6))
                    push_word(1'b0, $urandom);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps. On every accepted
    // beat the model is stepped and the owed event, if any, is queued.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk) begin
        beat_rec_t rec;
        result_t   ev;
        bit        hit;
        if (item_valid && !item_stall) begin
            rec = blob_words.pop_front();
            hit = parse_word(rec.it, ev);
            words_taken++;
            if (rec.typed) begin
                if (rec.typed_has)
                    pending_events.push_back(rec.typed_res);
            end else if (hit) begin
                pending_events.push_back(ev);
            end
        end
        if (item_valid && item_stall) begin
            // stalled beat holds still
        end else if (!rst_n) begin
            item_valid <= 1'b0;
        end else if (gap_left != 0) begin
            item_valid <= 1'b0;
            gap_left--;
        end else if (blob_words.size() != 0) begin
            item_valid <= 1'b1;
            item       <= blob_words[0].it;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end else begin
            item_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall modes that change at random intervals, plus one
    // long hold-off once traffic is flowing so the pipe backs up into
    // item_stall while the sender keeps offering.
    // ------------------------------------------------------------------
    int          hold_left     = 0;
    bit          pressure_done = 1'b0;
    int          mode_left     = 0;
    int          stall_mode    = 0;
    logic [31:0] stall_pat     = '0;
    int          pat_pos       = 0;

    always @(posedge clk) begin
        logic nxt;
        if (!pressure_done && words_taken >= 150) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            nxt = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_pat  = $urandom;
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            pat_pos++;
            case (stall_mode)
                0:       nxt = 1'b0;
                1:       nxt = stall_pat[pat_pos % 32];
                2:       nxt = 1'($urandom_range(0, 1));
                default: nxt = ($urandom_range(0, 3) != 0);
            endcase
        end
        result_stall <= nxt;
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result beat against the oldest owed event.
    // ------------------------------------------------------------------
    function automatic void check_field(input string fname, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    always @(posedge clk) begin
        result_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (pending_events.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual event %0d",
                         $time, result.event_res);
                err_cnt++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_res",      32'(want.event_res),  32'(result.event_res));
                check_field("name_chars",     want.name_chars,      result.name_chars);
                check_field("name_count",     32'(want.name_count), 32'(result.name_count));
                check_field("name_last",      32'(want.name_last),  32'(result.name_last));
                check_field("prop_length",    want.prop_length,     result.prop_length);
                check_field("prop_name_addr", want.prop_name_addr,  result.prop_name_addr);
                check_field("data_addr",      want.data_addr,       result.data_addr);
            end
        end
    end

    // Watchdog
    int cycle_cnt = 0;

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d events still owed", $time, pending_events.size());
            $display("** devicetree_blob_token_parser_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    // Waits until every beat is taken and every event has come back, then
    // lets the pipe settle (words that owe nothing may still be in flight).
    task automatic drain_and_settle();
        while (blob_words.size() != 0 || item_valid || pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // blob_base write; the model takes the value at the same edge
    task automatic write_base(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        base_addr = v;
        cfg_valid <= 1'b0;
    endtask

    beat_rec_t dir_table [28];

    initial begin
        logic [31:0] base_val;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed blob with blob_base still at its reset value of zero.
        // Structure offset 22 is unaligned and rounds down to word 5, so the
        // begin-node at word 4 is still skipped. Strings offset near the top
        // makes the property name address wrap.
        dir_table = '{
            lit (1'b1, DT_MAGIC,         1'b0, '0),
            lit (1'b0, 32'hFFFF_FFFF,    1'b0, '0),
            lit (1'b0, 32'd22,           1'b0, '0),
            lit (1'b0, 32'hFFFF_FFF0,    1'b0, '0),
            lit (1'b0, TOK_BEGIN_NODE,   1'b0, '0),              // still seeking
            pred(1'b0, TOK_BEGIN_NODE),
            lit (1'b0, 32'h0,            1'b1, name_res(ROOT_NAME, 3'd1, 1'b1, 32'd28)),
            lit (1'b0, TOK_NOP,          1'b0, '0),
            lit (1'b0, 32'hFFFF_FFFF,    1'b0, '0),              // unknown token
            pred(1'b0, TOK_PROP),
            pred(1'b0, 32'd0),                                   // zero-length value
            pred(1'b0, 32'h0000_0020),
            pred(1'b0, TOK_PROP),
            pred(1'b0, 32'd5),                                   // two padded words
            pred(1'b0, 32'hFFFF_FFFF),
            lit (1'b0, TOK_END,          1'b0, '0),              // value, skipped
            lit (1'b0, TOK_END_NODE,     1'b0, '0),              // value, skipped
            pred(1'b0, TOK_BEGIN_NODE),
            pred(1'b0, 32'hFF80_6162),                           // full four-char chunk
            lit (1'b0, 32'h0,            1'b1, name_res(32'h0, 3'd0, 1'b1, 32'd80)),
            pred(1'b0, TOK_BEGIN_NODE),
            pred(1'b0, 32'h4100_FFFF),                           // junk after terminator
            lit (1'b0, TOK_END_NODE,     1'b1, ev_only(EV_NODE_END)),
            lit (1'b0, TOK_END_NODE,     1'b1, ev_only(EV_NODE_END)),
            lit (1'b0, TOK_END,          1'b1, ev_only(EV_STRUCT_END)),
            lit (1'b0, TOK_BEGIN_NODE,   1'b0, '0),              // ignored once done
            lit (1'b1, 32'h0,            1'b1, ev_only(EV_MAGIC_ERR)),
            lit (1'b0, DT_MAGIC,         1'b0, '0)               // ignored after error
        };
        foreach (dir_table[i])
            blob_words.push_back(dir_table[i]);
        drain_and_settle();

        // Random phases, each under its own blob_base, extremes included.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       base_val = 32'hFFFF_FFFF;
                1:       base_val = 32'h0000_0000;
                2:       base_val = 32'h8000_0000;
                default: base_val = $urandom;
            endcase
            write_base(base_val);
            words_made = 0;
            while (words_made < PHASE_WORDS) begin
                if ($urandom_range(0, 9) < 8)
                    gen_blob();
                else
                    gen_noise();
            end
            drain_and_settle();
        end

        if (err_cnt == 0)
            $display("** devicetree_blob_token_parser_top: PASSED **");
        else
            $display("** devicetree_blob_token_parser_top: FAILED **");
        $finish;
    end

endmodule
